[rtl/core/triangle_unit_normal_defines.svh]
// Assertion macros for the triangle unit normal block.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`ifndef SYNTHESIS
`define TUN_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tun check failed");
`define TUN_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tun next-cycle check failed");
`else
`define TUN_ASSERT(name, clk, rst_n, prop)
`define TUN_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif
`endif

[rtl/core/tun_pkg.sv]
// Package for the triangle unit normal block: widths, payload and stage types.
// No dependencies.
`timescale 1ns / 1ps
package tun_pkg;
  localparam int CoordBits = 16;
  localparam int NormBits  = 16;
  localparam int FracBits  = 14;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int MagBits   = ProdBits;
  localparam int HalfBits  = MagBits / 2;
  localparam int SumBits   = 2 * MagBits;
  localparam int RootBits  = MagBits;
  localparam int RemBits   = MagBits + 3;
  localparam int DivBits   = MagBits + 1;
  localparam int QBits     = FracBits + 1;
  localparam int FrontRegs = 6;
  localparam int PipeRegs  = FrontRegs + (RootBits + 1) + (QBits + 1);

  typedef struct packed {
    logic signed [CoordBits-1:0] a_x;
    logic signed [CoordBits-1:0] a_y;
    logic signed [CoordBits-1:0] a_z;
    logic signed [CoordBits-1:0] b_x;
    logic signed [CoordBits-1:0] b_y;
    logic signed [CoordBits-1:0] b_z;
    logic signed [CoordBits-1:0] c_x;
    logic signed [CoordBits-1:0] c_y;
    logic signed [CoordBits-1:0] c_z;
  } in_t;

  typedef struct packed {
    logic signed [NormBits-1:0] norm_x;
    logic signed [NormBits-1:0] norm_y;
    logic signed [NormBits-1:0] norm_z;
    logic                       degenerate;
  } out_t;

  typedef struct packed {
    logic [2:0][MagBits-1:0] mag;
    logic [2:0]              neg;
  } cr_t;

  typedef struct packed {
    cr_t                 cr;
    logic [SumBits-1:0]  s;
    logic [RootBits-1:0] root;
    logic [RemBits-1:0]  rem;
  } sq_t;

  typedef struct packed {
    logic [2:0]              neg;
    logic [RootBits-1:0]     len;
    logic [2:0][DivBits-1:0] rem;
    logic [2:0][QBits-1:0]   q;
  } dv_t;
endpackage

[rtl/core/triangle_unit_normal.sv]
// Triangle unit normal: cross product, integer square root and restoring divide.
// Depends on tun_pkg and triangle_unit_normal_defines.svh.
//
// Usage: the input channel (in_valid_i, in_data_i, in_stall_o) transfers one
// triangle of three signed Q8.8 vertices; the output channel (out_valid_o,
// out_data_o, out_stall_i) transfers one signed Q2.14 unit normal with a
// degenerate flag per triangle, in input order.
// Throughput: one triangle per cycle while the receiver does not stall. The pipeline is
// 6 front stages (differences, products, cross, partial squares, squares,
// partial sum), 35 stages of the square root (the final sum, then one root bit
// per stage) and 16 stages of the divider (a load stage, then one quotient
// bit per stage, three components in parallel), then the output register.
// Stall: while the output register holds an untransferred result and the
// receiver stalls, the whole pipeline freezes and in_stall_o is raised;
// nothing is dropped or repeated.
// Reset: all valid bits clear at once; the block takes a transfer in the first
// cycle after reset.
`timescale 1ns / 1ps
`include "triangle_unit_normal_defines.svh"
module triangle_unit_normal (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  tun_pkg::in_t  in_data_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output tun_pkg::out_t out_data_o,
  input  logic          out_stall_i
);
  import tun_pkg::*;

  logic                en;
  logic [PipeRegs-1:0] vld_q;
  logic                out_v_q;
  out_t                out_q;

  logic signed [DiffBits-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
  logic signed [ProdBits-1:0] p_q [6];
  cr_t                        cr_q, cr4_q, cr5_q, cr6_q;
  logic [2:0][MagBits-1:0]    hh_q, hl_q, ll_q;
  logic [2:0][SumBits-1:0]    sq_q;
  logic [SumBits-1:0]         s01_q, s2_q;
  sq_t                        rt_q [RootBits+1];
  dv_t                        dv_q [QBits+1];

  function automatic logic signed [DiffBits-1:0] diff(logic signed [CoordBits-1:0] a,
                                                      logic signed [CoordBits-1:0] b);
    diff = DiffBits'(a) - DiffBits'(b);
  endfunction

  function automatic logic [MagBits:0] cross_mag(logic signed [ProdBits-1:0] a,
                                                 logic signed [ProdBits-1:0] b);
    logic signed [ProdBits:0] c;
    logic        [ProdBits:0] m;
    c = {a[ProdBits-1], a} - {b[ProdBits-1], b};
    m = c[ProdBits] ? (~c + 1'b1) : c;
    cross_mag = {c[ProdBits], m[MagBits-1:0]};
  endfunction

  function automatic sq_t root_step(sq_t x);
    sq_t                r;
    logic [RemBits-1:0] rem2;
    logic [RemBits-1:0] trial;
    logic               ge;
    r     = x;
    rem2  = {x.rem[RemBits-3:0], x.s[SumBits-1 -: 2]};
    trial = RemBits'({x.root, 2'b01});
    ge    = rem2 >= trial;
    r.rem  = ge ? (rem2 - trial) : rem2;
    r.root = {x.root[RootBits-2:0], ge};
    r.s    = x.s << 2;
    return r;
  endfunction

  function automatic dv_t div_step(dv_t x);
    dv_t                r;
    logic [DivBits-1:0] len;
    logic [DivBits-1:0] r1;
    logic               ge;
    r   = x;
    len = DivBits'(x.len);
    for (int k = 0; k < 3; k++) begin
      ge       = x.rem[k] >= len;
      r1       = ge ? (x.rem[k] - len) : x.rem[k];
      r.rem[k] = r1 << 1;
      r.q[k]   = {x.q[k][QBits-2:0], ge};
    end
    return r;
  endfunction

  function automatic logic signed [NormBits-1:0] signed_q(logic [QBits-1:0] q, logic neg);
    logic [NormBits-1:0] m;
    m = NormBits'(q);
    signed_q = neg ? (~m + 1'b1) : m;
  endfunction

  assign en          = !(out_v_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[PipeRegs-2:0], in_valid_i};
      out_v_q <= vld_q[PipeRegs-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ux_q <= diff(in_data_i.a_x, in_data_i.b_x);
      uy_q <= diff(in_data_i.a_y, in_data_i.b_y);
      uz_q <= diff(in_data_i.a_z, in_data_i.b_z);
      vx_q <= diff(in_data_i.b_x, in_data_i.c_x);
      vy_q <= diff(in_data_i.b_y, in_data_i.c_y);
      vz_q <= diff(in_data_i.b_z, in_data_i.c_z);

      p_q[0] <= ProdBits'(uy_q) * ProdBits'(vz_q);
      p_q[1] <= ProdBits'(uz_q) * ProdBits'(vy_q);
      p_q[2] <= ProdBits'(uz_q) * ProdBits'(vx_q);
      p_q[3] <= ProdBits'(ux_q) * ProdBits'(vz_q);
      p_q[4] <= ProdBits'(ux_q) * ProdBits'(vy_q);
      p_q[5] <= ProdBits'(uy_q) * ProdBits'(vx_q);

      for (int k = 0; k < 3; k++) begin
        {cr_q.neg[k], cr_q.mag[k]} <= cross_mag(p_q[2*k], p_q[2*k+1]);
      end

      cr4_q <= cr_q;
      for (int k = 0; k < 3; k++) begin
        hh_q[k] <= MagBits'(cr_q.mag[k][MagBits-1:HalfBits])
                   * MagBits'(cr_q.mag[k][MagBits-1:HalfBits]);
        hl_q[k] <= MagBits'(cr_q.mag[k][MagBits-1:HalfBits])
                   * MagBits'(cr_q.mag[k][HalfBits-1:0]);
        ll_q[k] <= MagBits'(cr_q.mag[k][HalfBits-1:0])
                   * MagBits'(cr_q.mag[k][HalfBits-1:0]);
      end

      cr5_q <= cr4_q;
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= (SumBits'(hh_q[k]) << MagBits) + (SumBits'(hl_q[k]) << (HalfBits + 1))
                   + SumBits'(ll_q[k]);
      end

      cr6_q <= cr5_q;
      s01_q <= sq_q[0] + sq_q[1];
      s2_q  <= sq_q[2];

      rt_q[0].cr   <= cr6_q;
      rt_q[0].s    <= s01_q + s2_q;
      rt_q[0].root <= '0;
      rt_q[0].rem  <= '0;

      dv_q[0].neg <= rt_q[RootBits].cr.neg;
      dv_q[0].len <= rt_q[RootBits].root;
      for (int k = 0; k < 3; k++) begin
        dv_q[0].rem[k] <= DivBits'(rt_q[RootBits].cr.mag[k]);
      end
      dv_q[0].q <= '0;

      if (dv_q[QBits].len == '0) begin
        out_q <= '{norm_x: '0, norm_y: '0, norm_z: '0, degenerate: 1'b1};
      end else begin
        out_q.norm_x     <= signed_q(dv_q[QBits].q[0], dv_q[QBits].neg[0]);
        out_q.norm_y     <= signed_q(dv_q[QBits].q[1], dv_q[QBits].neg[1]);
        out_q.norm_z     <= signed_q(dv_q[QBits].q[2], dv_q[QBits].neg[2]);
        out_q.degenerate <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < RootBits; g++) begin : g_root
    always_ff @(posedge clk_i) begin
      if (en) begin
        rt_q[g+1] <= root_step(rt_q[g]);
      end
    end
  end

  for (genvar g = 0; g < QBits; g++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[g+1] <= div_step(dv_q[g]);
      end
    end
  end

  `TUN_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> (out_v_q && out_stall_i))
  `TUN_ASSERT_NEXT(a_freeze, clk_i, rst_ni, in_stall_o, $stable(vld_q))
  `TUN_ASSERT(a_degen_zero, clk_i, rst_ni,
    (out_v_q && out_q.degenerate) |->
    (out_q.norm_x == '0 && out_q.norm_y == '0 && out_q.norm_z == '0))
  `TUN_ASSERT(a_norm_range, clk_i, rst_ni,
    out_v_q |-> (out_q.norm_x >= -16'sd16384 && out_q.norm_x <= 16'sd16384 &&
                 out_q.norm_z >= -16'sd16384 && out_q.norm_z <= 16'sd16384))
endmodule

[dv/tb_triangle_unit_normal.sv]
// Testbench for triangle_unit_normal: random and directed triangles with a
// self-contained fixed-point normal predictor and an in-order scoreboard.
// Depends on tun_pkg and the triangle_unit_normal RTL.
`timescale 1ns / 1ps

class normal_scoreboard;
  tun_pkg::out_t pending_q[$];
  int fail_cnt;

  function automatic logic [127:0] isqrt(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] t;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic tun_pkg::out_t predict(tun_pkg::in_t t);
    tun_pkg::out_t o;
    longint ux, uy, uz, vx, vy, vz;
    longint cr[3];
    logic [127:0] sum, len, m, q;
    ux = longint'(t.a_x) - longint'(t.b_x);
    uy = longint'(t.a_y) - longint'(t.b_y);
    uz = longint'(t.a_z) - longint'(t.b_z);
    vx = longint'(t.b_x) - longint'(t.c_x);
    vy = longint'(t.b_y) - longint'(t.c_y);
    vz = longint'(t.b_z) - longint'(t.c_z);
    cr[0] = uy * vz - uz * vy;
    cr[1] = uz * vx - ux * vz;
    cr[2] = ux * vy - uy * vx;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      m = (cr[k] < 0) ? 128'(-cr[k]) : 128'(cr[k]);
      sum += m * m;
    end
    len = isqrt(sum);
    o = '0;
    if (len == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    for (int k = 0; k < 3; k++) begin
      m = (cr[k] < 0) ? 128'(-cr[k]) : 128'(cr[k]);
      q = (m << tun_pkg::FracBits) / len;
      if (cr[k] < 0) q = -q;
      case (k)
        0: o.norm_x = q[15:0];
        1: o.norm_y = q[15:0];
        default: o.norm_z = q[15:0];
      endcase
    end
    return o;
  endfunction

  function void note_triangle(tun_pkg::in_t t);
    pending_q.push_back(predict(t));
  endfunction

  function void check_normal(tun_pkg::out_t got);
    tun_pkg::out_t exp_n;
    if (pending_q.size() == 0) begin
      $error("unexpected result %h", got);
      fail_cnt++;
      return;
    end
    exp_n = pending_q.pop_front();
    if (got.norm_x !== exp_n.norm_x) begin
      $error("norm_x exp %0d got %0d", exp_n.norm_x, got.norm_x);
      fail_cnt++;
    end
    if (got.norm_y !== exp_n.norm_y) begin
      $error("norm_y exp %0d got %0d", exp_n.norm_y, got.norm_y);
      fail_cnt++;
    end
    if (got.norm_z !== exp_n.norm_z) begin
      $error("norm_z exp %0d got %0d", exp_n.norm_z, got.norm_z);
      fail_cnt++;
    end
    if (got.degenerate !== exp_n.degenerate) begin
      $error("degenerate exp %0b got %0b", exp_n.degenerate, got.degenerate);
      fail_cnt++;
    end
  endfunction
endclass

module tb_triangle_unit_normal;
  import tun_pkg::*;

  localparam int NumRandom = 1750;
  localparam int Latency   = 58;
  localparam int IdleLimit = 2000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  in_t  in_data_i;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;
  logic out_stall_i;

  normal_scoreboard sb;
  in_t              tri_q[$];
  bit               stim_done;
  int               idle_cycles;

  triangle_unit_normal DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t rand_triangle();
    in_t t;
    t = in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    case ($urandom_range(0, 9))
      0: begin
        t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
      end
      1: begin
        t.c_x = t.b_x + (t.b_x - t.a_x);
        t.c_y = t.b_y + (t.b_y - t.a_y);
        t.c_z = t.b_z + (t.b_z - t.a_z);
      end
      2: begin
        t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
        t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
        t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
      end
      3: begin
        t.a_z = t.b_z; t.c_z = t.b_z;
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic send_triangle(in_t t);
    int gap;
    gap = $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_triangle(t);
  endtask

  initial begin
    in_t t;
    sb = new();
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b1;
    rst_ni      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    tri_q.push_back('0);
    t = '0; t.b_x = 16'h0100; t.c_y = 16'h0100;
    tri_q.push_back(t);
    t = '0; t.a_x = 16'h7fff; t.b_y = 16'h7fff; t.c_z = 16'h7fff;
    tri_q.push_back(t);
    t = '0; t.a_x = 16'h8000; t.a_y = 16'h8000; t.c_x = 16'h7fff; t.b_z = 16'h7fff;
    tri_q.push_back(t);
    t = {9{16'h8000}}; tri_q.push_back(t);
    t = {9{16'h7fff}}; tri_q.push_back(t);
    t = '0; t.a_x = 16'h8000; t.a_y = 16'h7fff; t.b_y = 16'h8000;
    t.b_z = 16'h7fff; t.c_x = 16'h7fff; t.c_z = 16'h8000;
    tri_q.push_back(t);
    t = '0; t.a_x = 16'h0001; t.b_y = 16'h0001; t.c_z = 16'hffff;
    tri_q.push_back(t);
    t = '0; t.a_x = 16'h0001; t.b_x = 16'h0002; t.c_x = 16'h0003;
    tri_q.push_back(t);
    t = '0; t.a_y = 16'h0300; t.c_z = 16'h0001;
    tri_q.push_back(t);
    t = {16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h0000, 16'h7fff,
         16'h0000, 16'h7fff, 16'h8000};
    tri_q.push_back(t);
    for (int i = 0; i < NumRandom; i++) tri_q.push_back(rand_triangle());

    foreach (tri_q[i]) send_triangle(tri_q[i]);
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stall per result, with calm stretches
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_normal(out_data_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done && sb.pending_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (sb.fail_cnt == 0 && sb.pending_q.size() == 0)
      $display("** triangle_unit_normal: PASSED **");
    else
      $display("** triangle_unit_normal: FAILED **");
    $finish;
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("** triangle_unit_normal: FAILED **");
    $finish;
  end
endmodule
